[hw/rtl/psd_pkg.sv]
// psd_pkg: widths, payload structs and saturation constants for the
// point-to-segment distance pipeline. No dependencies.

package psd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int EXT_W       = COORD_WIDTH + 2;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int NUM_W       = SQ_W;
    localparam int LEN_W       = 2 * COORD_WIDTH + 1;
    localparam int PROD_W      = LEN_W + COORD_WIDTH;
    localparam int POS_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int TN_W        = POS_W + 2;
    localparam int DIV_STEPS   = POS_W;
    localparam int DIST_W      = 2 * COORD_WIDTH + 3;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] qx;
        logic signed [COORD_WIDTH-1:0] qy;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
    } psd_pt_t;

    // One restoring-division lane: partial remainder and a shared word that
    // shifts dividend bits out of the top and quotient bits in at the bottom.
    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [POS_W-1:0] word;
    } psd_lane_t;

    typedef struct packed {
        psd_pt_t          pt;
        logic [LEN_W-1:0] len;
        logic             neg;
        logic             zero_len;
        logic             at_start;
        logic             at_end;
        logic             ovf;
        logic             dx_neg;
        logic             dy_neg;
    } psd_side_t;

    typedef struct packed {
        psd_side_t side;
        psd_lane_t pos;
        psd_lane_t lx;
        psd_lane_t ly;
    } psd_div_t;

    typedef struct packed {
        logic signed [POS_W-1:0]       position;
        logic signed [COORD_WIDTH-1:0] nearest_x;
        logic signed [COORD_WIDTH-1:0] nearest_y;
        logic [DIST_W-1:0]             dist_squared;
    } psd_res_t;

endpackage

[hw/rtl/psd_front.sv]
// psd_front: five-stage front end that forms the dot product, squared length
// and the seeds of the three division lanes. Depends on psd_pkg.

module psd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               src_valid,
    input  psd_pkg::psd_pt_t   src_pt,
    output logic               div_valid,
    output psd_pkg::psd_div_t  div_data
);

    // stage 1: differences
    logic                                 s1_valid_reg;
    psd_pkg::psd_pt_t                     s1_pt_reg;
    logic signed [psd_pkg::DIFF_W-1:0]    s1_dx_reg, s1_dy_reg, s1_px_reg, s1_py_reg;
    logic signed [psd_pkg::DIFF_W-1:0]    s1_dx_next, s1_dy_next, s1_px_next, s1_py_next;

    // stage 2: products
    logic                                 s2_valid_reg;
    psd_pkg::psd_pt_t                     s2_pt_reg;
    logic signed [psd_pkg::DIFF_W-1:0]    s2_dx_reg, s2_dy_reg;
    logic signed [psd_pkg::SQ_W-1:0]      s2_dxx_reg, s2_dyy_reg, s2_pdx_reg, s2_pdy_reg;
    logic signed [psd_pkg::SQ_W-1:0]      s2_dxx_next, s2_dyy_next, s2_pdx_next, s2_pdy_next;

    // stage 3: sums
    logic                                 s3_valid_reg;
    psd_pkg::psd_pt_t                     s3_pt_reg;
    logic signed [psd_pkg::DIFF_W-1:0]    s3_dx_reg, s3_dy_reg;
    logic [psd_pkg::LEN_W-1:0]            s3_len_reg, s3_len_next;
    logic signed [psd_pkg::NUM_W-1:0]     s3_num_reg, s3_num_next;

    // stage 4: magnitudes and region flags
    logic                                 s4_valid_reg;
    psd_pkg::psd_pt_t                     s4_pt_reg;
    logic [psd_pkg::LEN_W-1:0]            s4_len_reg;
    logic [psd_pkg::LEN_W-1:0]            s4_mag_reg, s4_mag_next;
    logic [psd_pkg::COORD_WIDTH-1:0]      s4_adx_reg, s4_adx_next, s4_ady_reg, s4_ady_next;
    logic                                 s4_neg_reg, s4_neg_next;
    logic                                 s4_start_reg, s4_start_next;
    logic                                 s4_end_reg, s4_end_next;
    logic                                 s4_zero_reg, s4_zero_next;
    logic                                 s4_dxn_reg, s4_dyn_reg;
    logic signed [psd_pkg::NUM_W-1:0]     s4_mag_full;
    logic signed [psd_pkg::DIFF_W-1:0]    s4_adx_full, s4_ady_full;

    // stage 5: division seeds
    logic                                 div_valid_reg;
    psd_pkg::psd_div_t                    div_data_reg, div_data_next;
    logic [psd_pkg::PROD_W-1:0]           s5_px, s5_py;
    logic [psd_pkg::LEN_W-1:0]            s5_int_part;

    always_comb
    begin
        s1_dx_next = psd_pkg::DIFF_W'(src_pt.bx) - psd_pkg::DIFF_W'(src_pt.ax);
        s1_dy_next = psd_pkg::DIFF_W'(src_pt.by) - psd_pkg::DIFF_W'(src_pt.ay);
        s1_px_next = psd_pkg::DIFF_W'(src_pt.qx) - psd_pkg::DIFF_W'(src_pt.ax);
        s1_py_next = psd_pkg::DIFF_W'(src_pt.qy) - psd_pkg::DIFF_W'(src_pt.ay);
    end

    always_comb
    begin
        s2_dxx_next = s1_dx_reg * s1_dx_reg;
        s2_dyy_next = s1_dy_reg * s1_dy_reg;
        s2_pdx_next = s1_px_reg * s1_dx_reg;
        s2_pdy_next = s1_py_reg * s1_dy_reg;
    end

    always_comb
    begin
        s3_len_next = psd_pkg::LEN_W'($unsigned(s2_dxx_reg))
                    + psd_pkg::LEN_W'($unsigned(s2_dyy_reg));
        s3_num_next = s2_pdx_reg + s2_pdy_reg;
    end

    always_comb
    begin
        s4_neg_next   = s3_num_reg[psd_pkg::NUM_W-1];
        s4_mag_full   = s4_neg_next ? -s3_num_reg : s3_num_reg;
        s4_mag_next   = psd_pkg::LEN_W'($unsigned(s4_mag_full));
        s4_adx_full   = s3_dx_reg[psd_pkg::DIFF_W-1] ? -s3_dx_reg : s3_dx_reg;
        s4_ady_full   = s3_dy_reg[psd_pkg::DIFF_W-1] ? -s3_dy_reg : s3_dy_reg;
        s4_adx_next   = psd_pkg::COORD_WIDTH'($unsigned(s4_adx_full));
        s4_ady_next   = psd_pkg::COORD_WIDTH'($unsigned(s4_ady_full));
        s4_start_next = s4_neg_next || (s3_num_reg == '0);
        s4_end_next   = !s4_neg_next && (s4_mag_next >= s3_len_reg);
        s4_zero_next  = (s3_len_reg == '0);
    end

    // Seed the lanes so that the remainder starts below the divisor: position
    // divides |num| << FRAC_W, the coordinate lanes divide |num| * |d|.
    always_comb
    begin
        s5_px       = s4_mag_reg * s4_adx_reg;
        s5_py       = s4_mag_reg * s4_ady_reg;
        s5_int_part = psd_pkg::LEN_W'(s4_mag_reg >> psd_pkg::FRAC_W);

        div_data_next.side.pt       = s4_pt_reg;
        div_data_next.side.len      = s4_len_reg;
        div_data_next.side.neg      = s4_neg_reg;
        div_data_next.side.zero_len = s4_zero_reg;
        div_data_next.side.at_start = s4_start_reg;
        div_data_next.side.at_end   = s4_end_reg;
        div_data_next.side.ovf      = (s5_int_part >= s4_len_reg);
        div_data_next.side.dx_neg   = s4_dxn_reg;
        div_data_next.side.dy_neg   = s4_dyn_reg;

        div_data_next.pos.rem  = s5_int_part;
        div_data_next.pos.word = {s4_mag_reg[psd_pkg::FRAC_W-1:0],
                                  {(psd_pkg::POS_W - psd_pkg::FRAC_W){1'b0}}};
        div_data_next.lx.rem   = psd_pkg::LEN_W'(s5_px >> psd_pkg::POS_W);
        div_data_next.lx.word  = s5_px[psd_pkg::POS_W-1:0];
        div_data_next.ly.rem   = psd_pkg::LEN_W'(s5_py >> psd_pkg::POS_W);
        div_data_next.ly.word  = s5_py[psd_pkg::POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= src_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            div_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pt_reg    <= src_pt;
            s1_dx_reg    <= s1_dx_next;
            s1_dy_reg    <= s1_dy_next;
            s1_px_reg    <= s1_px_next;
            s1_py_reg    <= s1_py_next;

            s2_pt_reg    <= s1_pt_reg;
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_dxx_reg   <= s2_dxx_next;
            s2_dyy_reg   <= s2_dyy_next;
            s2_pdx_reg   <= s2_pdx_next;
            s2_pdy_reg   <= s2_pdy_next;

            s3_pt_reg    <= s2_pt_reg;
            s3_dx_reg    <= s2_dx_reg;
            s3_dy_reg    <= s2_dy_reg;
            s3_len_reg   <= s3_len_next;
            s3_num_reg   <= s3_num_next;

            s4_pt_reg    <= s3_pt_reg;
            s4_len_reg   <= s3_len_reg;
            s4_mag_reg   <= s4_mag_next;
            s4_adx_reg   <= s4_adx_next;
            s4_ady_reg   <= s4_ady_next;
            s4_neg_reg   <= s4_neg_next;
            s4_start_reg <= s4_start_next;
            s4_end_reg   <= s4_end_next;
            s4_zero_reg  <= s4_zero_next;
            s4_dxn_reg   <= s3_dx_reg[psd_pkg::DIFF_W-1];
            s4_dyn_reg   <= s3_dy_reg[psd_pkg::DIFF_W-1];

            div_data_reg <= div_data_next;
        end
    end

    assign div_valid = div_valid_reg;
    assign div_data  = div_data_reg;

endmodule

[hw/rtl/psd_div_cell.sv]
// psd_div_cell: one restoring-division step on the position lane and both
// coordinate lanes, registered. Depends on psd_pkg.

module psd_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               up_valid,
    input  psd_pkg::psd_div_t  up_data,
    output logic               dn_valid,
    output psd_pkg::psd_div_t  dn_data
);

    logic               dn_valid_reg;
    psd_pkg::psd_div_t  dn_data_reg, dn_data_next;

    // Shift in the next dividend bit; subtract the divisor when it fits.
    function automatic psd_pkg::psd_lane_t div_step(input psd_pkg::psd_lane_t lane,
                                                    input logic [psd_pkg::LEN_W-1:0] len);
        logic [psd_pkg::LEN_W:0] trial;
        logic [psd_pkg::LEN_W:0] diff;
        logic                    fits;
        psd_pkg::psd_lane_t      res;
        trial    = {lane.rem, lane.word[psd_pkg::POS_W-1]};
        diff     = trial - {1'b0, len};
        fits     = (trial >= {1'b0, len});
        res.rem  = fits ? diff[psd_pkg::LEN_W-1:0] : trial[psd_pkg::LEN_W-1:0];
        res.word = {lane.word[psd_pkg::POS_W-2:0], fits};
        return res;
    endfunction

    always_comb
    begin
        dn_data_next      = up_data;
        dn_data_next.pos  = div_step(up_data.pos, up_data.side.len);
        dn_data_next.lx   = div_step(up_data.lx, up_data.side.len);
        dn_data_next.ly   = div_step(up_data.ly, up_data.side.len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dn_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_data_reg <= dn_data_next;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_data  = dn_data_reg;

endmodule

[hw/rtl/psd_back.sv]
// psd_back: four-stage back end: sign fix and saturation of t, nearest point
// selection, and the squared distance. Depends on psd_pkg.

module psd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               div_valid,
    input  psd_pkg::psd_div_t  div_data,
    output logic               res_valid,
    output psd_pkg::psd_res_t  res_data
);

    // stage 1: position and nearest point
    logic                                   b1_valid_reg;
    logic signed [psd_pkg::POS_W-1:0]       b1_pos_reg, b1_pos_next;
    logic signed [psd_pkg::COORD_WIDTH-1:0] b1_nx_reg, b1_nx_next, b1_ny_reg, b1_ny_next;
    logic signed [psd_pkg::COORD_WIDTH-1:0] b1_qx_reg, b1_qy_reg;
    logic signed [psd_pkg::TN_W-1:0]        b1_tn;
    logic [psd_pkg::POS_W-1:0]              b1_q;
    logic                                   b1_rnz;

    // stage 2: error vector
    logic                                   b2_valid_reg;
    logic signed [psd_pkg::POS_W-1:0]       b2_pos_reg;
    logic signed [psd_pkg::COORD_WIDTH-1:0] b2_nx_reg, b2_ny_reg;
    logic signed [psd_pkg::DIFF_W-1:0]      b2_ex_reg, b2_ex_next, b2_ey_reg, b2_ey_next;

    // stage 3: squares
    logic                                   b3_valid_reg;
    logic signed [psd_pkg::POS_W-1:0]       b3_pos_reg;
    logic signed [psd_pkg::COORD_WIDTH-1:0] b3_nx_reg, b3_ny_reg;
    logic signed [psd_pkg::SQ_W-1:0]        b3_ex2_next, b3_ey2_next;
    logic [psd_pkg::SQ_W-1:0]               b3_ex2_reg, b3_ey2_reg;

    // stage 4: result
    logic                                   b4_valid_reg;
    psd_pkg::psd_res_t                      b4_res_reg, b4_res_next;

    function automatic logic signed [psd_pkg::COORD_WIDTH-1:0] near_coord(
        input logic signed [psd_pkg::COORD_WIDTH-1:0] a,
        input logic signed [psd_pkg::COORD_WIDTH-1:0] b,
        input psd_pkg::psd_lane_t                     lane,
        input logic                                   dneg,
        input psd_pkg::psd_side_t                     side);
        logic signed [psd_pkg::EXT_W-1:0] a_e;
        logic signed [psd_pkg::EXT_W-1:0] off;
        logic signed [psd_pkg::EXT_W-1:0] inner;
        logic                             rnz;
        a_e   = psd_pkg::EXT_W'(a);
        off   = psd_pkg::EXT_W'({1'b0, lane.word[psd_pkg::COORD_WIDTH-1:0]});
        rnz   = |lane.rem;
        // floor toward minus infinity: a negative offset with a nonzero remainder rounds one further down
        inner = dneg ? (a_e - off - psd_pkg::EXT_W'(rnz)) : (a_e + off);
        if (side.zero_len || side.at_start)
            return a;
        else if (side.at_end)
            return b;
        else
            return inner[psd_pkg::COORD_WIDTH-1:0];
    endfunction

    always_comb
    begin
        b1_q   = div_data.pos.word;
        b1_rnz = |div_data.pos.rem;
        b1_tn  = -$signed({2'b00, b1_q}) - psd_pkg::TN_W'(b1_rnz);
        if (div_data.side.zero_len)
            b1_pos_next = '0;
        else if (div_data.side.ovf)
            b1_pos_next = div_data.side.neg ? psd_pkg::POS_MIN : psd_pkg::POS_MAX;
        else if (!div_data.side.neg)
            b1_pos_next = b1_q[psd_pkg::POS_W-1] ? psd_pkg::POS_MAX : $signed(b1_q);
        else if (b1_tn < psd_pkg::TN_W'(psd_pkg::POS_MIN))
            b1_pos_next = psd_pkg::POS_MIN;
        else
            b1_pos_next = b1_tn[psd_pkg::POS_W-1:0];

        b1_nx_next = near_coord(div_data.side.pt.ax, div_data.side.pt.bx, div_data.lx,
                                div_data.side.dx_neg, div_data.side);
        b1_ny_next = near_coord(div_data.side.pt.ay, div_data.side.pt.by, div_data.ly,
                                div_data.side.dy_neg, div_data.side);
    end

    always_comb
    begin
        b2_ex_next = psd_pkg::DIFF_W'(b1_qx_reg) - psd_pkg::DIFF_W'(b1_nx_reg);
        b2_ey_next = psd_pkg::DIFF_W'(b1_qy_reg) - psd_pkg::DIFF_W'(b1_ny_reg);
    end

    always_comb
    begin
        b3_ex2_next = b2_ex_reg * b2_ex_reg;
        b3_ey2_next = b2_ey_reg * b2_ey_reg;
    end

    always_comb
    begin
        b4_res_next.position     = b3_pos_reg;
        b4_res_next.nearest_x    = b3_nx_reg;
        b4_res_next.nearest_y    = b3_ny_reg;
        b4_res_next.dist_squared = psd_pkg::DIST_W'(b3_ex2_reg) + psd_pkg::DIST_W'(b3_ey2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= div_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_pos_reg <= b1_pos_next;
            b1_nx_reg  <= b1_nx_next;
            b1_ny_reg  <= b1_ny_next;
            b1_qx_reg  <= div_data.side.pt.qx;
            b1_qy_reg  <= div_data.side.pt.qy;

            b2_pos_reg <= b1_pos_reg;
            b2_nx_reg  <= b1_nx_reg;
            b2_ny_reg  <= b1_ny_reg;
            b2_ex_reg  <= b2_ex_next;
            b2_ey_reg  <= b2_ey_next;

            b3_pos_reg <= b2_pos_reg;
            b3_nx_reg  <= b2_nx_reg;
            b3_ny_reg  <= b2_ny_reg;
            b3_ex2_reg <= $unsigned(b3_ex2_next);
            b3_ey2_reg <= $unsigned(b3_ey2_next);

            b4_res_reg <= b4_res_next;
        end
    end

    assign res_valid = b4_valid_reg;
    assign res_data  = b4_res_reg;

endmodule

[hw/rtl/point_segment_distance_squared.sv]
// point_segment_distance_squared: top level; uses psd_pkg, psd_front, psd_div_cell, psd_back.
// Data flows through psd_front, the division chain, psd_back and the output register.
// Throughput: while the skid is empty, one beat per cycle; a new item enters the chain
// every cycle. Each item walks 32 restoring-division cells, one quotient bit per cell.
// Reset: rst_n (async, active low) clears every valid flag and the skid flag;
// data registers are not reset.

module point_segment_distance_squared (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   query_valid,
    output logic                                   query_stall,
    input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_x,
    input  logic signed [psd_pkg::COORD_WIDTH-1:0] query_y,
    input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_x,
    input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_y,
    input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_x,
    input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_y,

    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [psd_pkg::POS_W-1:0]       position,
    output logic signed [psd_pkg::COORD_WIDTH-1:0] nearest_x,
    output logic signed [psd_pkg::COORD_WIDTH-1:0] nearest_y,
    output logic [psd_pkg::DIST_W-1:0]             dist_squared
);

    // The whole pipeline moves together under one enable. The enable drops only
    // while the skid register holds a beat, so it comes straight from a flop and
    // the output stall never reaches the input stall through logic.
    logic               en;
    psd_pkg::psd_pt_t   src_pt;

    logic               cell_valid [psd_pkg::DIV_STEPS+1];
    psd_pkg::psd_div_t  cell_data  [psd_pkg::DIV_STEPS+1];

    logic               res_valid;
    psd_pkg::psd_res_t  res_data;

    logic               out_valid_reg, out_valid_next;
    psd_pkg::psd_res_t  out_data_reg, out_data_next;
    logic               skid_full_reg, skid_full_next;
    psd_pkg::psd_res_t  skid_data_reg, skid_data_next;
    logic               take;

    assign en = !skid_full_reg;

    always_comb
    begin
        src_pt.qx = query_x;
        src_pt.qy = query_y;
        src_pt.ax = start_x;
        src_pt.ay = start_y;
        src_pt.bx = end_x;
        src_pt.by = end_y;
    end

    // Front end: differences, products, dot product and squared length, then
    // the lane seeds. Five register stages.
    psd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (query_valid),
        .src_pt    (src_pt),
        .div_valid (cell_valid[0]),
        .div_data  (cell_data[0])
    );

    // Division chain: every cell retires one quotient bit of t and of both
    // coordinate offsets, and hands the beat to its neighbor.
    genvar gi;
    generate
        for (gi = 0; gi < psd_pkg::DIV_STEPS; gi++)
        begin : g_cell
            psd_div_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .up_valid (cell_valid[gi]),
                .up_data  (cell_data[gi]),
                .dn_valid (cell_valid[gi+1]),
                .dn_data  (cell_data[gi+1])
            );
        end
    endgenerate

    // Back end: saturate t, pick the nearest point, square the error. Four stages.
    psd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .div_valid (cell_valid[psd_pkg::DIV_STEPS]),
        .div_data  (cell_data[psd_pkg::DIV_STEPS]),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Output register plus one skid entry. A beat leaving the back end while the
    // output is stalled parks in the skid; the chain then holds until the
    // output drains, and the skid refills the output register.
    assign take = out_valid_reg && !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        if (skid_full_reg)
        begin
            if (take)
            begin
                out_data_next  = skid_data_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
            end
            else
            begin
                skid_full_next = 1'b1;
                skid_data_next = res_data;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign query_stall  = skid_full_reg;
    assign result_valid = out_valid_reg;
    assign position     = out_data_reg.position;
    assign nearest_x    = out_data_reg.nearest_x;
    assign nearest_y    = out_data_reg.nearest_y;
    assign dist_squared = out_data_reg.dist_squared;

    // A parked beat always sits behind a beat at the output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    // The skid only fills when the output was stalled.
    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && result_stall))
        else $error("skid filled without an output stall");

    // Drain the skid on the first free output cycle.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !result_stall |=> !skid_full_reg)
        else $error("skid not drained after the output was taken");

endmodule

[tb/point_segment_distance_squared_tb.sv]
// Self-checking bench for point_segment_distance_squared: drives query beats,
// predicts position, nearest point and squared distance, and checks each result.
// Depends on psd_pkg and the point_segment_distance_squared RTL.
`timescale 1ns / 100ps

// Holds the projections still owed by the block and checks arriving results.
class projection_scoreboard;
    psd_pkg::psd_res_t pending_projections[$];
    int mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Floor division for a positive divisor.
    static function longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // Project the query point onto the segment, all in exact integers.
    function psd_pkg::psd_res_t project(psd_pkg::psd_pt_t pt);
        longint qx, qy, ax, ay, bx, by;
        longint dx, dy, px, py, len, num, t, nx, ny, ex, ey, dist_sq;
        psd_pkg::psd_res_t r;
        qx = pt.qx;
        qy = pt.qy;
        ax = pt.ax;
        ay = pt.ay;
        bx = pt.bx;
        by = pt.by;
        dx = bx - ax;
        dy = by - ay;
        px = qx - ax;
        py = qy - ay;
        len = dx * dx + dy * dy;
        t = 0;
        nx = ax;
        ny = ay;
        if (len != 0)
        begin
            num = px * dx + py * dy;
            t = floor_div(num * 65536, len);
            if (t > longint'(psd_pkg::POS_MAX))
                t = longint'(psd_pkg::POS_MAX);
            else if (t < longint'(psd_pkg::POS_MIN))
                t = longint'(psd_pkg::POS_MIN);
            if (num >= len)
            begin
                nx = bx;
                ny = by;
            end
            else if (num > 0)
            begin
                nx = ax + floor_div(num * dx, len);
                ny = ay + floor_div(num * dy, len);
            end
        end
        ex = qx - nx;
        ey = qy - ny;
        dist_sq = ex * ex + ey * ey;
        r.position = t[psd_pkg::POS_W-1:0];
        r.nearest_x = nx[psd_pkg::COORD_WIDTH-1:0];
        r.nearest_y = ny[psd_pkg::COORD_WIDTH-1:0];
        r.dist_squared = dist_sq[psd_pkg::DIST_W-1:0];
        return r;
    endfunction

    function void note_query(psd_pkg::psd_pt_t pt);
        pending_projections.push_back(project(pt));
    endfunction

    function void check_result(psd_pkg::psd_res_t got);
        psd_pkg::psd_res_t want;
        if (pending_projections.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat with no query pending: pos %0d near (%0d,%0d) dist %0d",
                         got.position, got.nearest_x, got.nearest_y, got.dist_squared);
            return;
        end
        want = pending_projections.pop_front();
        if (got.position !== want.position || got.nearest_x !== want.nearest_x ||
            got.nearest_y !== want.nearest_y || got.dist_squared !== want.dist_squared)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: expected pos %0d near (%0d,%0d) dist %0d",
                         want.position, want.nearest_x, want.nearest_y, want.dist_squared);
                $display("          actual   pos %0d near (%0d,%0d) dist %0d",
                         got.position, got.nearest_x, got.nearest_y, got.dist_squared);
            end
        end
    endfunction

    function int pending();
        return pending_projections.size();
    endfunction

    function int failures();
        return mismatches + pending_projections.size();
    endfunction
endclass

module point_segment_distance_squared_tb;

    typedef logic signed [psd_pkg::COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(psd_pkg::COORD_WIDTH - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(psd_pkg::COORD_WIDTH - 1){1'b0}}};

    // Random query beats after the directed set.
    localparam int RANDOM_QUERIES = 1350;
    // Cycles without any accepted beat before the run is called hung.
    localparam int QUIET_LIMIT = 3000;
    // Drain time after the last result: pipeline depth plus margin.
    localparam int SETTLE_CYCLES = 60;

    // Idle modes shared by both sides: no gaps, normal gaps, heavy gaps.
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_NORMAL = 1;
    localparam int IDLE_HEAVY  = 2;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;

    logic   query_valid = 1'b0;
    logic   query_stall;
    coord_t query_x = '0;
    coord_t query_y = '0;
    coord_t start_x = '0;
    coord_t start_y = '0;
    coord_t end_x = '0;
    coord_t end_y = '0;

    logic                               result_valid;
    logic                               result_stall = 1'b0;
    logic signed [psd_pkg::POS_W-1:0]   position;
    coord_t                             nearest_x;
    coord_t                             nearest_y;
    logic [psd_pkg::DIST_W-1:0]         dist_squared;

    projection_scoreboard board;
    int send_mode = IDLE_NORMAL;
    int drain_mode = IDLE_NORMAL;
    int quiet_cycles = 0;
    int stall_left = 0;

    point_segment_distance_squared dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length for one side: mostly short, now and then long.
    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(99);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_HEAVY)
        begin
            if (r < 30) return 0;
            if (r < 70) return $urandom_range(1, 4);
            if (r < 92) return $urandom_range(5, 15);
            return $urandom_range(20, 60);
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom());
    endfunction

    // Uniform in [-span, span].
    function automatic coord_t near_coord(int span);
        return coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Pick among the corners of the coordinate range, zero, minus one, or random.
    function automatic coord_t edge_coord();
        case ($urandom_range(4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return '1;
            default: return any_coord();
        endcase
    endfunction

    function automatic psd_pkg::psd_pt_t make_pt(int qx, int qy, int ax, int ay,
                                                 int bx, int by);
        psd_pkg::psd_pt_t pt;
        pt.qx = coord_t'(qx);
        pt.qy = coord_t'(qy);
        pt.ax = coord_t'(ax);
        pt.ay = coord_t'(ay);
        pt.bx = coord_t'(bx);
        pt.by = coord_t'(by);
        return pt;
    endfunction

    // Mix of query shapes: wide random, dense near the origin, tiny segments
    // (saturating positions), zero-length segments, exact end-point hits and
    // extreme coordinates.
    function automatic psd_pkg::psd_pt_t random_query();
        psd_pkg::psd_pt_t pt;
        int kind, k;
        coord_t dx, dy, base_x, base_y;
        kind = $urandom_range(99);
        pt.qx = any_coord();
        pt.qy = any_coord();
        pt.ax = any_coord();
        pt.ay = any_coord();
        pt.bx = any_coord();
        pt.by = any_coord();
        if (kind < 35)
        begin
        end
        else if (kind < 55)
        begin
            pt.qx = near_coord(256);
            pt.qy = near_coord(256);
            pt.ax = near_coord(256);
            pt.ay = near_coord(256);
            pt.bx = near_coord(256);
            pt.by = near_coord(256);
        end
        else if (kind < 70)
        begin
            pt.bx = pt.ax + near_coord(3);
            pt.by = pt.ay + near_coord(3);
        end
        else if (kind < 80)
        begin
            pt.bx = pt.ax;
            pt.by = pt.ay;
            if ($urandom_range(3) == 0)
            begin
                pt.qx = pt.ax;
                pt.qy = pt.ay;
            end
        end
        else if (kind < 90)
        begin
            // Put the query on the perpendicular through one end point, so the
            // dot product lands exactly on zero or on the squared length.
            pt.ax = near_coord(2000);
            pt.ay = near_coord(2000);
            dx = near_coord(200);
            dy = near_coord(200);
            pt.bx = pt.ax + dx;
            pt.by = pt.ay + dy;
            k = int'(near_coord(4));
            base_x = $urandom_range(1) ? pt.bx : pt.ax;
            base_y = (base_x == pt.bx && dx != 0) ? pt.by : pt.ay;
            if (dx == 0)
                base_y = $urandom_range(1) ? pt.by : pt.ay;
            pt.qx = base_x - coord_t'(k * int'(dy));
            pt.qy = base_y + coord_t'(k * int'(dx));
        end
        else
        begin
            pt.qx = edge_coord();
            pt.qy = edge_coord();
            pt.ax = edge_coord();
            pt.ay = edge_coord();
            pt.bx = edge_coord();
            pt.by = edge_coord();
        end
        return pt;
    endfunction

    // Present one query beat, hold it until accepted, note it, then maybe idle.
    // Called at a rising edge; returns at a rising edge.
    task automatic send_query(input psd_pkg::psd_pt_t pt);
        int gap;
        query_valid <= 1'b1;
        query_x <= pt.qx;
        query_y <= pt.qy;
        start_x <= pt.ax;
        start_y <= pt.ay;
        end_x <= pt.bx;
        end_y <= pt.by;
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
        board.note_query(pt);
        gap = pick_gap(send_mode);
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: check every accepted result beat, then decide the stall
    // for the next cycle. A stall run lasts the picked gap length, and every
    // run is followed by at least one open cycle. The mode switches now and
    // then so that long back-pressure, light jitter and free flow all occur.
    always @(posedge clk)
    begin : drain
        psd_pkg::psd_res_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.position = position;
            got.nearest_x = nearest_x;
            got.nearest_y = nearest_y;
            got.dist_squared = dist_squared;
            board.check_result(got);
        end
        if ($urandom_range(149) == 0)
            drain_mode = $urandom_range(IDLE_HEAVY);
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else
            stall_left = pick_gap(drain_mode);
        result_stall <= (stall_left > 0);
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (query_valid && !query_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed set: zero-length segments
        send_query(make_pt(100, -50, 20, 30, 20, 30));
        send_query(make_pt(32767, 32767, -32768, -32768, -32768, -32768));
        // Query on the first end point, and on the perpendicular through it
        send_query(make_pt(-48, 16, -48, 16, 320, -96));
        send_query(make_pt(0, 50, 0, 0, 16, 0));
        // Before the start
        send_query(make_pt(-30, 5, 0, 0, 16, 0));
        // Query on the second end point, on its perpendicular, and past it
        send_query(make_pt(16, 32, 0, 0, 16, 32));
        send_query(make_pt(16, -40, 0, 0, 16, 0));
        send_query(make_pt(100, 7, 0, 0, 16, 0));
        // Interior with negative direction components: floor toward minus infinity
        send_query(make_pt(5, 5, 10, 0, 0, 3));
        send_query(make_pt(3, 50, 100, 100, -7, -13));
        send_query(make_pt(37, 3, 0, -100, 0, 100));
        // Position saturation, both directions, and the values just inside
        send_query(make_pt(32767, 0, -32768, 0, -32767, 0));
        send_query(make_pt(-32768, 0, 32766, 0, 32767, 0));
        send_query(make_pt(-32768, 0, 0, 0, 1, 0));
        send_query(make_pt(32767, 0, 0, 0, 1, 0));
        // Full-span segments and alternating bit patterns
        send_query(make_pt(32767, -32768, -32768, -32768, 32767, 32767));
        send_query(make_pt(-32768, 32767, 32767, -32768, -32768, 32767));
        send_query(make_pt(0, 0, -32768, 32767, 32767, -32768));
        send_query(make_pt(21845, -21846, -21846, 21845, 21845, 21845));
        send_query(make_pt(-21846, 21845, 21845, -21846, -21846, -21846));

        for (int n = 0; n < RANDOM_QUERIES; n++)
        begin
            if (n % 50 == 0)
                send_mode = $urandom_range(IDLE_HEAVY);
            send_query(random_query());
        end
        query_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.failures() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/psd_pkg.sv
hw/rtl/psd_front.sv
hw/rtl/psd_div_cell.sv
hw/rtl/psd_back.sv
hw/rtl/point_segment_distance_squared.sv
tb/point_segment_distance_squared_tb.sv
